### src/http_header_name_classifier_unit_assert.svh
// Assertion macros for the header name classifier
`ifndef HTTP_HEADER_NAME_CLASSIFIER_UNIT_ASSERT_SVH
`define HTTP_HEADER_NAME_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HHNC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HHNC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define HHNC_ASSERT_IMPL(label, clk, rst_n, prop)
`define HHNC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/hhnc_pkg.sv
// Package: keyword table, lengths and repeat flags for the header name classifier
`timescale 1ns / 1ps
`default_nettype none
package hhnc_pkg;
    localparam int NumKw  = 93;
    localparam int KwLen  = 32;
    localparam int CodeW  = 7;
    localparam int SeenW  = 6;
    localparam logic [SeenW-1:0] SeenMax = 6'd63;

    typedef logic [7:0]        t_byte;
    typedef logic [CodeW-1:0]  t_code;
    typedef logic [SeenW-1:0]  t_seen;
    typedef logic [NumKw-1:0]  t_kw_vec;

    typedef struct packed {
        logic  found;
        t_code code;
        logic  rep;
    } t_result;

    typedef struct packed {
        t_byte name_byte;
        logic  name_end;
    } t_item;

    // keyword text, left aligned, padded with zero bytes
    localparam logic [KwLen*8-1:0] KwText [NumKw] = '{
        {"Host",224'd0},{"Cache-Control",152'd0},{"Connection",176'd0},
        {"Accept",208'd0},{"Accept-Language",136'd0},{"Accept-Encoding",136'd0},
        {"User-Agent",176'd0},{"Referer",200'd0},{"X-Forwarded-For",136'd0},
        {"Origin",208'd0},{"Upgrade-Insecure-Requests",56'd0},{"Pragma",208'd0},
        {"Cookie",208'd0},{"DNT",232'd0},{"Sec-GPC",200'd0},{"From",224'd0},
        {"If-Modified-Since",120'd0},{"X-Requested-With",128'd0},
        {"X-Forwarded-Host",128'd0},{"X-Forwarded-Proto",120'd0},
        {"X-CSRF-Token",160'd0},{"Save-Data",184'd0},{"Range",216'd0},
        {"Content-Length",144'd0},{"Content-Type",160'd0},{"Vary",224'd0},
        {"Date",224'd0},{"Server",208'd0},{"Expires",200'd0},
        {"Content-Encoding",128'd0},{"Last-Modified",152'd0},{"ETag",224'd0},
        {"Allow",216'd0},{"Content-Range",152'd0},{"Accept-Charset",144'd0},
        {"Access-Control-Allow-Credentials"},
        {"Access-Control-Allow-Headers",32'd0},
        {"Access-Control-Allow-Methods",32'd0},
        {"Access-Control-Allow-Origin",40'd0},{"Access-Control-MaxAge",88'd0},
        {"Access-Control-Method",88'd0},
        {"Access-Control-Request-Headers",16'd0},
        {"Access-Control-Request-Method",24'd0},
        {"Access-Control-Request-Methods",16'd0},
        {"Age",232'd0},{"Authorization",152'd0},{"Content-Base",160'd0},
        {"Content-Description",104'd0},{"Content-Disposition",104'd0},
        {"Content-Language",128'd0},{"Content-Location",128'd0},
        {"Content-MD5",168'd0},{"Expect",208'd0},{"If-Match",192'd0},
        {"If-None-Match",152'd0},{"If-Range",192'd0},
        {"If-Unmodified-Since",104'd0},{"Keep-Alive",176'd0},{"Link",224'd0},
        {"Location",192'd0},{"Max-Forwards",160'd0},
        {"Proxy-Authenticate",112'd0},{"Proxy-Authorization",104'd0},
        {"Proxy-Connection",128'd0},{"Public",208'd0},{"Retry-After",168'd0},
        {"TE",240'd0},{"Trailer",200'd0},{"Transfer-Encoding",120'd0},
        {"Upgrade",200'd0},{"Warning",200'd0},{"WWW-Authenticate",128'd0},
        {"Via",232'd0},{"Strict-Transport-Security",56'd0},
        {"X-Frame-Options",136'd0},{"X-Content-Type-Options",80'd0},
        {"Alt-Svc",200'd0},{"Referrer-Policy",136'd0},
        {"X-XSS-Protection",128'd0},{"Accept-Ranges",152'd0},
        {"Set-Cookie",176'd0},{"Sec-CH-UA",184'd0},{"Sec-CH-UA-Mobile",128'd0},
        {"Sec-CH-UA-Platform",112'd0},{"Sec-Fetch-Site",144'd0},
        {"Sec-Fetch-Mode",144'd0},{"Sec-Fetch-User",144'd0},
        {"Sec-Fetch-Dest",144'd0},{"CF-RAY",208'd0},{"CF-Visitor",176'd0},
        {"CF-Connecting-IP",128'd0},{"CF-IPCountry",160'd0},{"CDN-Loop",192'd0}
    };

    localparam logic [NumKw-1:0] KwRep = {
        1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0, // 92..83
        1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0, // 82..73
        1'b1,1'b1,1'b1,1'b1,1'b1,1'b1,1'b1,1'b0,1'b1,1'b0, // 72..63
        1'b0,1'b1,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b1,1'b1, // 62..53
        1'b1,1'b0,1'b0,1'b1,1'b0,1'b0,1'b0,1'b0,1'b0,1'b1, // 52..43
        1'b0,1'b1,1'b0,1'b0,1'b0,1'b1,1'b1,1'b0,1'b1,1'b0, // 42..33
        1'b1,1'b0,1'b0,1'b1,1'b0,1'b0,1'b0,1'b1,1'b0,1'b0, // 32..23
        1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0, // 22..13
        1'b0,1'b1,1'b0,1'b0,1'b1,1'b0,1'b0,1'b1,1'b1,1'b1, // 12..3
        1'b0,1'b1,1'b0                                     // 2..0
    };

    function automatic t_byte fold(input t_byte c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic t_seen kw_len(input int k);
        t_seen n;
        n = '0;
        for (int i = 0; i < KwLen; i++) begin
            if (KwText[k][KwLen*8-1-8*i -: 8] != 8'h00) begin
                n = t_seen'(i + 1);
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

### src/hhnc_stream_if.sv
// Valid/ready stream interface
`timescale 1ns / 1ps
`default_nettype none
interface hhnc_stream_if #(parameter int Width = 9);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/hhnc_match.sv
// Per-keyword live vector and position counter
`timescale 1ns / 1ps
`default_nettype none
module hhnc_match import hhnc_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_take,
    input  t_item    i_item,
    output t_kw_vec  o_hit,
    output logic     o_last
);
    t_kw_vec r_alive, n_alive, w_hit;
    t_seen   r_seen;
    t_byte   w_fb;

    always_comb begin
        w_fb = fold(i_item.name_byte);
        for (int k = 0; k < NumKw; k++) begin
            n_alive[k] = r_alive[k];
            if (r_seen < kw_len(k)) begin
                if (w_fb != fold(KwText[k][KwLen*8-1-8*r_seen[4:0] -: 8])) begin
                    n_alive[k] = 1'b0;
                end
            end
            // count = seen+1 >= len
            w_hit[k] = n_alive[k] && ({1'b0, kw_len(k)} <= {1'b0, r_seen} + 7'd1);
        end
    end

    assign o_hit  = w_hit;
    assign o_last = i_item.name_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '1;
            r_seen  <= '0;
        end else if (i_take) begin
            if (i_item.name_end) begin
                r_alive <= '1;
                r_seen  <= '0;
            end else begin
                r_alive <= n_alive;
                r_seen  <= (r_seen == SeenMax) ? SeenMax : r_seen + 6'd1;
            end
        end
    end
endmodule
`default_nettype wire

### src/hhnc_prio.sv
// First-hit priority select with repeat flag lookup
`timescale 1ns / 1ps
`default_nettype none
module hhnc_prio import hhnc_pkg::*; (
    input  t_kw_vec i_hit,
    output t_result o_res
);
    always_comb begin
        o_res = '0;
        for (int k = NumKw - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                o_res.found = 1'b1;
                o_res.code  = t_code'(k);
                o_res.rep   = KwRep[k];
            end
        end
    end
endmodule
`default_nettype wire

### src/http_header_name_classifier_unit.sv
// Top level: HTTP header name keyword classifier
`timescale 1ns / 1ps
`default_nettype none
`include "http_header_name_classifier_unit_assert.svh"
// All keywords compare in parallel against the live vector; a name's result is registered
// when its last byte is taken. Throughput: one byte per cycle unless a held result stalls.
// The output register frees as it transfers, so a new byte is taken while a result leaves.
// Reset: synchronous active low; all keywords live, position zero, output empty.
module http_header_name_classifier_unit import hhnc_pkg::*; (
    input  wire i_clk,
    input  wire i_rst_n,
    hhnc_stream_if.sink   i_in,
    hhnc_stream_if.source o_out
);
    t_item   w_item;
    t_kw_vec w_hit;
    logic    w_last, w_take;
    t_result w_res, r_res;
    logic    r_valid;

    assign w_item = t_item'(i_in.data);
    // stall only when a result waits and cannot leave
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_take = i_in.valid && i_in.ready;

    hhnc_match u_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_item (w_item),
        .o_hit  (w_hit),
        .o_last (w_last)
    );

    hhnc_prio u_prio (
        .i_hit(w_hit),
        .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take && w_last) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_res;

    `HHNC_ASSERT_NEXT(a_res_load, i_clk, i_rst_n, w_take && w_last, o_out.valid)
    `HHNC_ASSERT_IMPL(a_code_zero, i_clk, i_rst_n, (o_out.valid && !r_res.found) |-> (r_res.code == '0 && !r_res.rep))
    `HHNC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(r_res))
endmodule
`default_nettype wire

### test/hhnc_checker.sv
// Scoreboard: predicts header classification from observed bytes and checks results
`timescale 1ns / 1ps
`default_nettype none
module hhnc_checker import hhnc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire [8:0]  i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire [8:0]  i_out_data,
    output int         o_fail_count,
    output int         o_pending
);
    string   keywords [NumKw];
    bit      may_repeat [NumKw];
    bit      live [NumKw];
    int      name_pos;
    t_result expected_q [$];

    initial begin
        keywords = '{"Host","Cache-Control","Connection","Accept","Accept-Language",
            "Accept-Encoding","User-Agent","Referer","X-Forwarded-For","Origin",
            "Upgrade-Insecure-Requests","Pragma","Cookie","DNT","Sec-GPC","From",
            "If-Modified-Since","X-Requested-With","X-Forwarded-Host",
            "X-Forwarded-Proto","X-CSRF-Token","Save-Data","Range","Content-Length",
            "Content-Type","Vary","Date","Server","Expires","Content-Encoding",
            "Last-Modified","ETag","Allow","Content-Range","Accept-Charset",
            "Access-Control-Allow-Credentials","Access-Control-Allow-Headers",
            "Access-Control-Allow-Methods","Access-Control-Allow-Origin",
            "Access-Control-MaxAge","Access-Control-Method",
            "Access-Control-Request-Headers","Access-Control-Request-Method",
            "Access-Control-Request-Methods","Age","Authorization","Content-Base",
            "Content-Description","Content-Disposition","Content-Language",
            "Content-Location","Content-MD5","Expect","If-Match","If-None-Match",
            "If-Range","If-Unmodified-Since","Keep-Alive","Link","Location",
            "Max-Forwards","Proxy-Authenticate","Proxy-Authorization",
            "Proxy-Connection","Public","Retry-After","TE","Trailer",
            "Transfer-Encoding","Upgrade","Warning","WWW-Authenticate","Via",
            "Strict-Transport-Security","X-Frame-Options","X-Content-Type-Options",
            "Alt-Svc","Referrer-Policy","X-XSS-Protection","Accept-Ranges",
            "Set-Cookie","Sec-CH-UA","Sec-CH-UA-Mobile","Sec-CH-UA-Platform",
            "Sec-Fetch-Site","Sec-Fetch-Mode","Sec-Fetch-User","Sec-Fetch-Dest",
            "CF-RAY","CF-Visitor","CF-Connecting-IP","CF-IPCountry","CDN-Loop"};
        may_repeat = '{0,1,0,1,1,1,0,0,1,0, 0,1,0,0,0,0,0,0,0,0,
                       0,0,0,0,0,1,0,0,0,1, 0,0,1,0,1,0,1,1,0,0,
                       0,1,0,1,0,0,0,0,0,1, 0,0,1,1,1,0,0,0,0,0,
                       0,1,0,0,1,0,1,1,1,1, 1,1,1,0,0,0,0,0,0,0,
                       0,0,0,0,0,0,0,0,0,0, 0,0,0};
    end

    function automatic t_byte to_lower(input t_byte c);
        return (c >= "A" && c <= "Z") ? c | 8'h20 : c;
    endfunction

    function automatic void restart_name();
        foreach (live[k]) live[k] = 1'b1;
        name_pos = 0;
    endfunction

    // advance the match state by one name byte; returns the result on the last byte
    function automatic bit classify_byte(input t_byte b, input bit last,
                                         output t_result res);
        int span;
        span = name_pos + 1;
        for (int k = 0; k < NumKw; k++) begin
            if (name_pos < keywords[k].len()
                    && to_lower(b) != to_lower(t_byte'(keywords[k][name_pos])))
                live[k] = 1'b0;
        end
        if (name_pos < 63) name_pos++;
        if (!last) return 1'b0;
        res = '0;
        for (int k = 0; k < NumKw; k++) begin
            if (live[k] && keywords[k].len() <= span) begin
                res.found = 1'b1;
                res.code  = t_code'(k);
                res.rep   = may_repeat[k];
                break;
            end
        end
        restart_name();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result res, got, want;
        if (!i_rst_n) begin
            restart_name();
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (classify_byte(i_in_data[8:1], i_in_data[0], res))
                    expected_q.push_back(res);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result found=%0b code=%0d rep=%0b",
                                 got.found, got.code, got.rep);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp found=%0b code=%0d rep=%0b, got found=%0b code=%0d rep=%0b",
                                     want.found, want.code, want.rep,
                                     got.found, got.code, got.rep);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end
endmodule
`default_nettype wire

### test/tb.sv
// Testbench top: byte-stream stimulus, backpressure phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import hhnc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;
    int   bytes_sent = 0;

    hhnc_stream_if #(.Width(9)) in_if ();
    hhnc_stream_if #(.Width(9)) out_if ();

    http_header_name_classifier_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if.sink), .o_out(out_if.source)
    );

    hhnc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .i_in_ready(in_if.ready), .i_in_data(in_if.data),
        .i_out_valid(out_if.valid), .i_out_ready(out_if.ready), .i_out_data(out_if.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.data  = '0;
        out_if.ready = 1'b0;
    end

    // result side backpressure
    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one byte transfer; starts and ends at a falling edge, valid left high
    // so the next byte can follow without a gap
    task automatic push_byte(input t_byte b, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {b, last};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_name(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(t_byte'(s[i]), i == s.len() - 1);
    endtask

    // random name: mostly keyword based with random case and damage, rest noise
    task automatic push_random_name();
        t_byte name [$];
        t_byte c;
        int k, mode, n;
        if ($urandom_range(99) < 80) begin
            k = $urandom_range(NumKw - 1);
            for (int i = 0; i < chk.keywords[k].len(); i++) begin
                c = t_byte'(chk.keywords[k][i]);
                if (((c | 8'h20) >= "a") && ((c | 8'h20) <= "z") && $urandom_range(1))
                    c = c ^ 8'h20;
                name.push_back(c);
            end
            mode = $urandom_range(9);
            if (mode >= 5 && mode <= 6) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
                repeat (n) name.push_back(t_byte'($urandom_range(32, 126)));
            end else if (mode == 7 && name.size() > 1) begin
                n = $urandom_range(1, name.size() - 1);
                repeat (n) void'(name.pop_back());
            end else if (mode >= 8) begin
                name[$urandom_range(name.size() - 1)] = t_byte'($urandom_range(255));
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) name.push_back(t_byte'($urandom_range(255)));
        end
        foreach (name[i]) push_byte(name[i], i == name.size() - 1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: case folding, short names, zero and high bytes
        push_name("HOST");
        push_name("tE");
        push_name("T");
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_name("cdn-LOOP");
        push_name("Dnt");
        push_name("aGe");

        // hold off until everything has drained
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);

        while (bytes_sent < 1350) begin
            case (bytes_sent * 4 / 1350)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            push_random_name();
        end
        in_if.valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+src
src/hhnc_pkg.sv
src/hhnc_stream_if.sv
src/hhnc_match.sv
src/hhnc_prio.sv
src/http_header_name_classifier_unit.sv
test/hhnc_checker.sv
test/tb.sv
